FILE: design/gda_pkg.sv
`default_nettype none

package gda_pkg;

  localparam int unsigned MaskWidth = 7;
  localparam logic [MaskWidth-1:0] WeekendMaskReset = 7'd96;

  localparam logic [2:0] Saturday = 3'd6;
  localparam logic [3:0] MonthFeb = 4'd2;
  localparam logic [3:0] MonthMar = 4'd3;
  localparam logic [3:0] MonthDec = 4'd12;
  localparam logic [12:0] Div25Mul = 13'd5243;
  localparam int unsigned Div25Shift = 17;

  typedef struct packed {
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
  } date_t;

  typedef struct packed {
    logic [2:0]  weekday;
    logic        end_of_week;
    logic        weekend;
    logic        leap_year;
    logic [4:0]  month_length;
    logic [8:0]  day_of_year;
    logic [2:0]  days_left_week;
    logic [4:0]  days_left_month;
    logic [8:0]  days_left_year;
    logic [4:0]  next_day;
    logic [3:0]  next_month;
    logic [13:0] next_year;
  } result_t;

  typedef struct packed {
    logic        leap_year;
    logic [4:0]  month_length;
    logic [8:0]  day_of_year;
    logic [4:0]  days_left_month;
    logic [8:0]  days_left_year;
    logic [4:0]  next_day;
    logic [3:0]  next_month;
    logic [13:0] next_year;
  } cal_t;

  // exact floor(x / 25) for any 13-bit x
  function automatic logic [8:0] div25(input logic [12:0] x);
    logic [25:0] prod;
    prod = 26'(x) * 26'(Div25Mul);
    return prod[25:Div25Shift];
  endfunction

  // octal digit folding, 8 = 1 mod 7
  function automatic logic [2:0] mod7(input logic [15:0] x);
    logic [5:0] s1;
    logic [3:0] s2;
    s1 = 6'(x[2:0]) + 6'(x[5:3]) + 6'(x[8:6]) + 6'(x[11:9]) + 6'(x[14:12]) + 6'(x[15]);
    s2 = 4'(s1[2:0]) + 4'(s1[5:3]);
    if (s2 >= 4'd7) begin
      s2 = s2 - 4'd7;
    end
    return s2[2:0];
  endfunction

  // floor(31 * shifted_month / 12)
  function automatic logic [5:0] month_offset(input logic [3:0] m);
    logic [5:0] r;
    unique case (m)
      4'd0:    r = 6'd25;
      4'd1:    r = 6'd28;
      4'd2:    r = 6'd31;
      4'd3:    r = 6'd2;
      4'd4:    r = 6'd5;
      4'd5:    r = 6'd7;
      4'd6:    r = 6'd10;
      4'd7:    r = 6'd12;
      4'd8:    r = 6'd15;
      4'd9:    r = 6'd18;
      4'd10:   r = 6'd20;
      4'd11:   r = 6'd23;
      4'd12:   r = 6'd25;
      4'd13:   r = 6'd28;
      4'd14:   r = 6'd31;
      default: r = 6'd33;
    endcase
    return r;
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] r;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                   r = 5'd30;
      4'd2:                                      r = leap ? 5'd29 : 5'd28;
      default:                                   r = 5'd0;
    endcase
    return r;
  endfunction

  // days in the months before m, common year
  function automatic logic [8:0] days_before(input logic [3:0] m);
    logic [8:0] r;
    unique case (m)
      4'd0, 4'd1: r = 9'd0;
      4'd2:       r = 9'd31;
      4'd3:       r = 9'd59;
      4'd4:       r = 9'd90;
      4'd5:       r = 9'd120;
      4'd6:       r = 9'd151;
      4'd7:       r = 9'd181;
      4'd8:       r = 9'd212;
      4'd9:       r = 9'd243;
      4'd10:      r = 9'd273;
      4'd11:      r = 9'd304;
      4'd12:      r = 9'd334;
      default:    r = 9'd365;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: design/gda_weekday.sv
`default_nettype none

module gda_weekday (
  input  var gda_pkg::date_t date,
  output logic [2:0]         weekday
);

  logic        jan_feb;
  logic [14:0] yy;
  logic [12:0] q4;
  logic [8:0]  q100;
  logic [6:0]  q400;
  logic [15:0] sum;

  always_comb begin
    jan_feb = (date.month <= gda_pkg::MonthFeb);
    // 400 extra years keep the sum positive without moving the weekday
    yy      = 15'(date.year) + 15'd400 - 15'(jan_feb);
    q4      = yy[14:2];
    q100    = gda_pkg::div25(q4);
    q400    = q100[8:2];
    sum     = 16'(date.day) + 16'(yy) + 16'(q4) - 16'(q100) + 16'(q400)
            + 16'(gda_pkg::month_offset(date.month));
    weekday = gda_pkg::mod7(sum);
  end

endmodule

`default_nettype wire

FILE: design/gda_calendar.sv
`default_nettype none

module gda_calendar (
  input  var gda_pkg::date_t date,
  output gda_pkg::cal_t      cal
);

  logic [11:0] y4;
  logic [8:0]  c;
  logic [12:0] rem;
  logic        leap;
  logic [4:0]  len;
  logic [8:0]  doy;
  logic [9:0]  ylen;
  logic [5:0]  lm;
  logic [9:0]  ly;
  logic        last_day;

  always_comb begin
    y4   = date.year[13:2];
    c    = gda_pkg::div25({1'b0, y4});
    rem  = {1'b0, y4} - 13'(c) * 13'd25;
    // divisible by 4; a century only when also divisible by 400
    leap = (date.year[1:0] == 2'b00) && ((rem != 13'd0) || (c[1:0] == 2'b00));
    len  = gda_pkg::month_len(date.month, leap);
    doy  = 9'(date.day) + gda_pkg::days_before(date.month)
         + 9'(leap && (date.month >= gda_pkg::MonthMar));
    ylen = leap ? 10'd366 : 10'd365;

    if (date.day <= len) begin
      lm = 6'(len) - 6'(date.day) + 6'd1;
    end else begin
      lm = 6'd1;
    end

    if (10'(doy) <= ylen) begin
      ly = ylen - 10'(doy) + 10'd1;
    end else begin
      ly = 10'd1;
    end

    last_day = (len != 5'd0) && (date.day >= len);

    cal.leap_year       = leap;
    cal.month_length    = len;
    cal.day_of_year     = doy;
    cal.days_left_month = lm[4:0];
    cal.days_left_year  = ly[8:0];
    cal.next_day        = last_day ? 5'd1 : date.day + 5'd1;
    cal.next_month      = date.month;
    cal.next_year       = date.year;
    if (last_day) begin
      if (date.month == gda_pkg::MonthDec) begin
        cal.next_month = 4'd1;
        cal.next_year  = date.year + 14'd1;
      end else begin
        cal.next_month = date.month + 4'd1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: design/gregorian_date_analyzer.sv
`default_nettype none

// Calendar facts for one Gregorian date per clock. A date is taken on every
// cycle with start high (busy never rises) and its result shows on result for
// the single cycle that done is high, which lies behind one register on the
// date, one on the result, with the weekday, leap-year, day-of-year and
// next-date logic between them. The receiver cannot stall, so results must be
// captured when done is high. The slowest path is the century count of the
// weekday (a 13 x 13 reciprocal multiply followed by a mod-7 fold). The weekend
// mask is written through cfg_data (always ready) and resets to Friday and
// Saturday; write it only while no date is in flight.

module gregorian_date_analyzer (
  input  var logic                              clk,
  input  var logic                              rst,
  input  var logic                              start,
  output logic                                  busy,
  input  var gda_pkg::date_t                    date,
  output logic                                  done,
  output gda_pkg::result_t                      result,
  input  var logic                              cfg_valid,
  output logic                                  cfg_ready,
  input  var logic [gda_pkg::MaskWidth-1:0]     cfg_data
);

  logic                          valid_q;
  gda_pkg::date_t                date_q;
  logic [gda_pkg::MaskWidth-1:0] weekend_mask;
  logic [2:0]                    wd;
  gda_pkg::cal_t                 cal;
  gda_pkg::result_t              result_next;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      weekend_mask <= gda_pkg::WeekendMaskReset;
    end else if (cfg_valid && cfg_ready) begin
      weekend_mask <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      date_q <= date;
    end
  end

  gda_weekday u_weekday (
    .date    (date_q),
    .weekday (wd)
  );

  gda_calendar u_calendar (
    .date (date_q),
    .cal  (cal)
  );

  always_comb begin
    result_next.weekday         = wd;
    result_next.end_of_week     = (wd == gda_pkg::Saturday);
    result_next.weekend         = weekend_mask[wd];
    result_next.leap_year       = cal.leap_year;
    result_next.month_length    = cal.month_length;
    result_next.day_of_year     = cal.day_of_year;
    result_next.days_left_week  = gda_pkg::Saturday - wd;
    result_next.days_left_month = cal.days_left_month;
    result_next.days_left_year  = cal.days_left_year;
    result_next.next_day        = cal.next_day;
    result_next.next_month      = cal.next_month;
    result_next.next_year       = cal.next_year;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= valid_q;
    end
  end

  always_ff @(posedge clk) begin
    if (valid_q) begin
      result <= result_next;
    end
  end

`ifndef SYNTHESIS
  a_latency: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##2 done)
    else $error("accepted date gave no result two cycles later");

  a_weekday_range: assert property (@(posedge clk) disable iff (rst)
    done |-> result.weekday <= gda_pkg::Saturday)
    else $error("weekday out of range");

  a_end_of_week: assert property (@(posedge clk) disable iff (rst)
    done |-> result.end_of_week == (result.days_left_week == 3'd0))
    else $error("end of week disagrees with days left in week");

  a_weekend: assert property (@(posedge clk) disable iff (rst)
    done && $stable(weekend_mask) |-> result.weekend == weekend_mask[result.weekday])
    else $error("weekend flag disagrees with mask");
`endif

endmodule

`default_nettype wire

FILE: bench/tb_gregorian_date_analyzer.sv
`timescale 1ns / 1ps

module tb_gregorian_date_analyzer;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned MaxReported = 10;
  localparam int unsigned SettleCycles = 4;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  gda_pkg::date_t date;
  logic done;
  gda_pkg::result_t result;
  logic cfg_valid;
  logic cfg_ready;
  logic [gda_pkg::MaskWidth-1:0] cfg_data;

  gda_pkg::result_t expected_cal[$];
  logic [gda_pkg::MaskWidth-1:0] weekend_sel;
  int unsigned mismatches;
  int unsigned cycles;
  bit burst;
  gda_pkg::result_t front_cal;

  gregorian_date_analyzer dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .date      (date),
    .done      (done),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  function automatic bit is_leap(int unsigned y);
    return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
  endfunction

  function automatic int unsigned month_days(int unsigned m, bit leap);
    if (m < 1 || m > 12) return 0;
    if (m == 2) return leap ? 29 : 28;
    if (m == 4 || m == 6 || m == 9 || m == 11) return 30;
    return 31;
  endfunction

  function automatic gda_pkg::result_t predict_calendar(
    gda_pkg::date_t dt,
    logic [gda_pkg::MaskWidth-1:0] mask
  );
    int unsigned d, m, y, a, yy, mm, s, wd, len, ylen, doy, lm, ly, nd, nm, ny;
    bit leap;
    gda_pkg::result_t r;
    d = dt.day;
    m = dt.month;
    y = dt.year;
    leap = is_leap(y);
    len = month_days(m, leap);
    ylen = leap ? 366 : 365;
    // shifted-month weekday, 400 years added to stay positive
    a = (m <= 2) ? 1 : 0;
    yy = y + 400 - a;
    mm = m + 12 * a - 2;
    s = d + yy + yy / 4 - yy / 100 + yy / 400 + (31 * mm) / 12;
    wd = s % 7;
    doy = d;
    for (int unsigned i = 1; i < m; i++) doy += month_days(i, leap);
    lm = (d <= len) ? len - d + 1 : 1;
    ly = (doy <= ylen) ? ylen - doy + 1 : 1;
    nd = d + 1;
    nm = m;
    ny = y;
    if (len != 0 && d >= len) begin
      nd = 1;
      if (m == 12) begin
        nm = 1;
        ny = y + 1;
      end else begin
        nm = m + 1;
      end
    end
    r.weekday         = wd[2:0];
    r.end_of_week     = (wd == 6);
    r.weekend         = mask[wd];
    r.leap_year       = leap;
    r.month_length    = len[4:0];
    r.day_of_year     = doy[8:0];
    r.days_left_week  = 3'(6 - wd);
    r.days_left_month = lm[4:0];
    r.days_left_year  = ly[8:0];
    r.next_day        = nd[4:0];
    r.next_month      = nm[3:0];
    r.next_year       = ny[13:0];
    return r;
  endfunction

  function automatic gda_pkg::date_t mk_date(int unsigned d, int unsigned m, int unsigned y);
    gda_pkg::date_t dt;
    dt.day = d[4:0];
    dt.month = m[3:0];
    dt.year = y[13:0];
    return dt;
  endfunction

  // mostly well-formed dates, some month ends, some raw bits
  function automatic gda_pkg::date_t pick_date();
    int unsigned m, y, len;
    if ($urandom_range(0, 9) < 2) return gda_pkg::date_t'($urandom);
    m = $urandom_range(1, 12);
    case ($urandom_range(0, 7))
      0: y = $urandom_range(0, 3) * 400 + $urandom_range(0, 3) * 100 + 1600;
      1: y = $urandom_range(9990, 9999);
      default: y = $urandom_range(1, 9999);
    endcase
    len = month_days(m, is_leap(y));
    if ($urandom_range(0, 3) == 0) return mk_date(len, m, y);
    return mk_date($urandom_range(1, len), m, y);
  endfunction

  task automatic send_item(gda_pkg::date_t dt);
    int unsigned idle;
    idle = burst ? 0 : $urandom_range(0, 8);
    if (idle > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (idle - 1) @(negedge clk);
    end
    @(negedge clk);
    start <= 1'b1;
    date <= dt;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_cal.push_back(predict_calendar(dt, weekend_sel));
  endtask

  task automatic settle();
    @(negedge clk);
    start <= 1'b0;
    while (expected_cal.size() != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  task automatic write_mask(logic [gda_pkg::MaskWidth-1:0] value);
    settle();
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    weekend_sel = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic report_mismatch(string what, gda_pkg::result_t want, gda_pkg::result_t got);
    mismatches++;
    if (mismatches <= MaxReported) begin
      $display("mismatch (%s) at cycle %0d", what, cycles);
      $display("  expected %p", want);
      $display("  actual   %p", got);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_cal.size() == 0) begin
        report_mismatch("unexpected result", '0, result);
      end else begin
        front_cal = expected_cal.pop_front();
        if (result !== front_cal) report_mismatch("field", front_cal, result);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  // reset mask, field extremes, rollovers and odd months
  task automatic test_directed();
    burst = 1'b0;
    send_item(mk_date(1, 1, 1));
    send_item(mk_date(31, 12, 9999));
    send_item(mk_date(31, 12, 16383));
    send_item(mk_date(0, 1, 0));
    send_item(mk_date(31, 1, 0));
    send_item(mk_date(31, 15, 16383));
    send_item(mk_date(29, 2, 2024));
    send_item(mk_date(28, 2, 2023));
    send_item(mk_date(29, 2, 1900));
    send_item(mk_date(29, 2, 2000));
    send_item(mk_date(31, 2, 2023));
    send_item(mk_date(30, 4, 2021));
    send_item(mk_date(31, 3, 2020));
    send_item(mk_date(1, 3, 2000));
    send_item(mk_date(0, 3, 2019));
    send_item(mk_date(15, 0, 2020));
    send_item(mk_date(10, 13, 2021));
    send_item(mk_date(31, 14, 2020));
    send_item(mk_date(5, 15, 2019));
    burst = 1'b1;
    send_item(mk_date(31, 12, 2020));
    send_item(mk_date(30, 11, 1999));
    send_item(mk_date(1, 2, 1600));
  endtask

  // one full week under each mask extreme
  task automatic test_mask_extremes();
    logic [gda_pkg::MaskWidth-1:0] masks[2];
    masks[0] = '0;
    masks[1] = '1;
    foreach (masks[k]) begin
      write_mask(masks[k]);
      burst = k[0];
      for (int unsigned d = 2; d <= 8; d++) send_item(mk_date(d, 6, 2024));
    end
  endtask

  task automatic test_random();
    for (int p = 0; p < 5; p++) begin
      write_mask(7'($urandom));
      burst = ($urandom_range(0, 2) == 0);
      for (int n = 0; n < 200; n++) send_item(pick_date());
    end
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    date = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    weekend_sel = gda_pkg::WeekendMaskReset;
    mismatches = 0;
    cycles = 0;
    burst = 1'b0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_mask_extremes();
    test_random();
    settle();

    if (mismatches == 0 && expected_cal.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: sim.f
design/gda_pkg.sv
design/gda_weekday.sv
design/gda_calendar.sv
design/gregorian_date_analyzer.sv
bench/tb_gregorian_date_analyzer.sv
